>>> design/assert_macros.svh
// Assertion helpers; clocked on clk_i, quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> design/mpeed_pkg.sv
package mpeed_pkg;

  localparam int unsigned SLOT_COUNT = 64;

  localparam logic [14:0] BEND_CENTER = 15'd8192;
  // half of 8191 and of 127 after the shared factor of two is taken out
  localparam logic [23:0] PITCH_HALF  = 24'd4095;
  localparam logic [23:0] UNIT_HALF   = 24'd63;
  // 65536 = 516 * 127 + 4
  localparam logic [9:0]  UNIT_SCALE  = 10'd516;
  localparam int unsigned UNIT_DIV    = 127;

  localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
  localparam logic [3:0] MSG_CTRL       = 4'hB;
  localparam logic [3:0] MSG_CHAN_PRESS = 4'hD;
  localparam logic [3:0] MSG_BEND       = 4'hE;
  localparam logic [3:0] MSG_SYSTEM     = 4'hF;

  localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
  localparam logic [6:0] CC_TIMBRE     = 7'd74;
  localparam logic [6:0] CC_RPN_LSB    = 7'd100;
  localparam logic [6:0] CC_RPN_MSB    = 7'd101;

  localparam logic [13:0] RPN_BEND_RANGE = 14'd0;
  localparam logic [13:0] RPN_ZONE_SIZE  = 14'd6;

  localparam logic [3:0] LOWER_MASTER = 4'd0;
  localparam logic [3:0] UPPER_MASTER = 4'd15;

  typedef enum logic [2:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_PITCH    = 3'd2,
    KIND_PRESSURE = 3'd3,
    KIND_TIMBRE   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_LOWER_MEMBERS   = 3'd0,
    CFG_UPPER_MEMBERS   = 3'd1,
    CFG_LOWER_MEM_RANGE = 3'd2,
    CFG_UPPER_MEM_RANGE = 3'd3,
    CFG_LOWER_MAS_RANGE = 3'd4,
    CFG_UPPER_MAS_RANGE = 3'd5,
    CFG_HONOUR          = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_NOTEON,
    S_WALK
  } state_e;

  typedef enum logic [1:0] {
    SEL_PITCH,
    SEL_PRESS,
    SEL_TIMBRE
  } vsel_e;

  function automatic kind_e kind_of(vsel_e sel);
    kind_e k;
    case (sel)
      SEL_PITCH: k = KIND_PITCH;
      SEL_PRESS: k = KIND_PRESSURE;
      default:   k = KIND_TIMBRE;
    endcase
    return k;
  endfunction

endpackage

>>> design/mpe_midi_note_expression_decoder_core.sv
// Decodes one MIDI channel message per start pulse into per-note events. busy_o is high from
// the accepting edge until the last result has been formed; results come one per cycle on
// result_valid_o, one register stage behind, and must be taken as they appear. Each value
// is formed by a load step and then a quotient step, a downward bend by the load step alone.
// A note-on keeps busy_o high through decode, multiply, pitch, pressure and timbre values,
// then four results back to back. An expression message forms its value and then walks the
// slot memory one slot per cycle up to the last live note plus one; a member message walks
// only its own channel's slots and a zone-wide master message those of its whole zone.
// Note-off decodes and walks the slots of its channel, stopping at the first match. Parameter
// and ignored messages return busy_o low right after decode. Write configuration only while
// busy_o is low and no result is still due.
`include "assert_macros.svh"

module mpe_midi_note_expression_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         status_byte_i,
  input  logic [6:0]         data_first_i,
  input  logic [6:0]         data_second_i,
  input  logic [15:0]        frame_offset_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [15:0]        event_frame_o,
  output logic [31:0]        note_id_o,
  output logic [2:0]         event_kind_o,
  output logic [3:0]         event_channel_o,
  output logic [6:0]         note_key_o,
  output logic [6:0]         note_velocity_o,
  output logic signed [23:0] event_value_o,
  output logic               last_of_run_o
);
  import mpeed_pkg::*;

  state_e state_q, state_d;

  logic [7:0]  st_q;
  logic [6:0]  d1_q, d2_q;
  logic [15:0] frame_q;

  logic [3:0] lcnt_q, ucnt_q;
  logic [6:0] lmem_rng_q, umem_rng_q, lmas_rng_q, umas_rng_q;
  logic       honour_q;

  logic [13:0] bend_q  [16];
  logic [6:0]  press_q [16];
  logic [6:0]  timb_q  [16];
  logic [13:0] pnum_q  [16];
  logic [15:0] pval_q;

  logic [SLOT_COUNT-1:0] active_q;
  logic [31:0]           next_id_q;

  logic [38:0] slot_mem [SLOT_COUNT];
  logic [6:0]  rd_key_q;
  logic [31:0] rd_id_q;

  logic        noteon_q, off_q;
  vsel_e       vsel_q;
  logic [13:0] bend_op_q;
  logic [6:0]  rng_op_q, press_op_q, timb_op_q;
  logic [31:0] new_id_q;
  logic signed [23:0] pitch_val_q, press_val_q, timb_val_q;
  logic signed [22:0] prod_q;
  logic [23:0]        val_base_q, val_tail_q;
  logic [1:0]         emit_cnt_q;

  logic [SLOT_COUNT-1:0] walk_mask_q;
  logic [5:0]            walk_idx_q, pend_slot_q;
  logic                  pend_q, pend_last_q;

  logic        res_valid_q, res_last_q;
  logic [15:0] res_frame_q;
  logic [31:0] res_id_q;
  logic [2:0]  res_kind_q;
  logic [3:0]  res_ch_q;
  logic [6:0]  res_key_q, res_vel_q;
  logic signed [23:0] res_val_q;

  // ---------------------------------------------------------------- decode
  logic [3:0]  typ, ch;
  logic        msg_ok, is_lmem, is_umem, member, lower, master;
  logic [4:0]  usum;
  logic [15:0] zone_ch;
  logic [SLOT_COUNT-1:0] zone_mask, chan_mask;
  logic [3:0]  ch_act;
  logic        free_hit;
  logic [1:0]  free_idx;
  logic        is_on, is_off, is_expr, is_param;
  logic [6:0]  mem_rng, mas_rng;
  logic [3:0]  size_clamp;

  assign typ = st_q[7:4];
  assign ch  = st_q[3:0];
  assign msg_ok  = st_q[7] && (typ != MSG_SYSTEM);
  assign is_lmem = (ch != 4'd0) && (ch <= lcnt_q);
  assign usum    = {1'b0, ch} + {1'b0, ucnt_q};
  assign is_umem = (usum >= 5'd15) && (ch != UPPER_MASTER);
  assign member  = is_lmem || is_umem;
  assign lower   = is_lmem || (!is_umem && ch == LOWER_MASTER);
  assign master  = !member && (ch == LOWER_MASTER || ch == UPPER_MASTER);
  assign mem_rng = lower ? lmem_rng_q : umem_rng_q;
  assign mas_rng = lower ? lmas_rng_q : umas_rng_q;
  assign size_clamp = (d2_q > 7'd15) ? 4'd15 : d2_q[3:0];

  always_comb begin
    logic [3:0] cv;
    for (int c = 0; c < 16; c++) begin
      cv = 4'(c);
      zone_ch[c] = lower ? (cv != 4'd0 && cv <= lcnt_q)
                         : (({1'b0, cv} + {1'b0, ucnt_q}) >= 5'd15 && cv != UPPER_MASTER);
      zone_mask[c*4 +: 4] = {4{zone_ch[c]}} & active_q[c*4 +: 4];
    end
  end

  assign chan_mask = active_q & ({{(SLOT_COUNT-4){1'b0}}, 4'hF} << {ch, 2'b00});
  assign ch_act    = active_q[{ch, 2'b00} +: 4];

  always_comb begin
    free_hit = 1'b0;
    free_idx = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (!ch_act[i]) begin
        free_hit = 1'b1;
        free_idx = 2'(i);
      end
    end
  end

  assign is_on    = member && typ == MSG_NOTE_ON && d2_q != 7'd0;
  assign is_off   = member && (typ == MSG_NOTE_OFF || typ == MSG_NOTE_ON) && !is_on;
  assign is_expr  = (member || master) && (typ == MSG_BEND || typ == MSG_CHAN_PRESS ||
                    (typ == MSG_CTRL && d1_q == CC_TIMBRE));
  assign is_param = (member || master) && typ == MSG_CTRL && d1_q != CC_TIMBRE;

  // ---------------------------------------------------------------- quotient
  // Upward pitch: 8p + (8p + 4095) / 8191; unit value: 516v + (4v + 63) / 127.
  logic [6:0]  unit_op;
  logic [15:0] unit_prod;
  logic [23:0] quo_sum;
  logic [2:0]  unit_quo;
  logic [10:0] quo;

  assign unit_op   = (vsel_q == SEL_PRESS) ? press_op_q : timb_op_q;
  assign unit_prod = {9'd0, unit_op} * {6'd0, UNIT_SCALE};
  // divide by 8191 as (t + t/8192 + 1) / 8192, exact while the quotient stays below 8192
  assign quo_sum   = val_tail_q + {13'd0, val_tail_q[23:13]} + 24'd1;

  always_comb begin
    unit_quo = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      if (val_tail_q >= 24'(k * UNIT_DIV)) unit_quo = 3'(k);
    end
  end

  always_comb begin
    quo = quo_sum[23:13];
    if (vsel_q != SEL_PITCH) quo = {8'd0, unit_quo};
  end

  logic signed [14:0] bend_off;
  assign bend_off = signed'({1'b0, bend_op_q} - BEND_CENTER);

  // ---------------------------------------------------------------- walk
  logic                  w_hit, match;
  logic [SLOT_COUNT-1:0] w_rem, mask_d;
  logic                  pend_d;

  assign w_hit = walk_mask_q[walk_idx_q];
  assign w_rem = walk_mask_q & ~({{(SLOT_COUNT-1){1'b0}}, 1'b1} << walk_idx_q);
  assign match = pend_q && off_q && rd_key_q == d1_q;

  always_comb begin
    mask_d = w_rem;
    pend_d = w_hit;
    if (match) begin
      // drop the rest of the scan once the first match is freed
      mask_d = '0;
      pend_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- control
  logic        store_v;
  logic signed [23:0] store_val;
  logic        emit_v, emit_last;
  kind_e       emit_kind;
  logic [31:0] emit_id;
  logic [3:0]  emit_ch;
  logic [6:0]  emit_key, emit_vel;
  logic signed [23:0] emit_val, walk_val;

  always_comb begin
    case (vsel_q)
      SEL_PITCH: walk_val = pitch_val_q;
      SEL_PRESS: walk_val = press_val_q;
      default:   walk_val = timb_val_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    store_v   = 1'b0;
    store_val = {prod_q[20:0], 3'b000};
    emit_v    = 1'b0;
    emit_last = 1'b0;
    emit_kind = KIND_NOTE_ON;
    emit_id   = new_id_q;
    emit_ch   = ch;
    emit_key  = d1_q;
    emit_vel  = 7'd0;
    emit_val  = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (!msg_ok) state_d = S_IDLE;
        else if (is_on) state_d = free_hit ? S_MUL : S_IDLE;
        else if (is_off) state_d = S_WALK;
        else if (is_expr) state_d = (typ == MSG_BEND) ? S_MUL : S_LOAD;
        else state_d = S_IDLE;
      end
      S_MUL: state_d = S_LOAD;
      S_LOAD: begin
        if (vsel_q == SEL_PITCH && prod_q[22]) begin
          // downward bend is exact: offset * range * 8
          store_v = 1'b1;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        store_v   = 1'b1;
        store_val = val_base_q + {13'd0, quo};
      end
      S_NOTEON: begin
        emit_v    = 1'b1;
        emit_last = (emit_cnt_q == 2'd3);
        case (emit_cnt_q)
          2'd0: begin
            emit_kind = KIND_NOTE_ON;
            emit_vel  = d2_q;
          end
          2'd1: begin
            emit_kind = KIND_PITCH;
            emit_val  = pitch_val_q;
          end
          2'd2: begin
            emit_kind = KIND_PRESSURE;
            emit_val  = press_val_q;
          end
          default: begin
            emit_kind = KIND_TIMBRE;
            emit_val  = timb_val_q;
          end
        endcase
        if (emit_cnt_q == 2'd3) state_d = S_IDLE;
      end
      S_WALK: begin
        emit_id  = rd_id_q;
        emit_key = rd_key_q;
        emit_ch  = pend_slot_q[5:2];
        if (off_q) begin
          emit_v    = match;
          emit_kind = KIND_NOTE_OFF;
          emit_vel  = d2_q;
          emit_last = 1'b1;
        end else begin
          emit_v    = pend_q;
          emit_kind = kind_of(vsel_q);
          emit_val  = walk_val;
          emit_last = pend_last_q;
        end
        if (mask_d == '0 && !pend_d) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (store_v) begin
      if (!noteon_q) state_d = S_WALK;
      else if (vsel_q == SEL_TIMBRE) state_d = S_NOTEON;
      else state_d = S_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // ---------------------------------------------------------------- slot memory
  logic [5:0] alloc_slot;
  assign alloc_slot = {ch, free_idx};

  always_ff @(posedge clk_i) begin
    if (state_q == S_DECODE && msg_ok && is_on && free_hit) begin
      slot_mem[alloc_slot] <= {d1_q, next_id_q + 32'd1};
    end
    {rd_key_q, rd_id_q} <= slot_mem[walk_idx_q];
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q      <= 4'd0;
      ucnt_q      <= 4'd0;
      lmem_rng_q  <= 7'd48;
      umem_rng_q  <= 7'd48;
      lmas_rng_q  <= 7'd2;
      umas_rng_q  <= 7'd2;
      honour_q    <= 1'b1;
      pval_q      <= '0;
      active_q    <= '0;
      next_id_q   <= '0;
      walk_mask_q <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int c = 0; c < 16; c++) begin
        bend_q[c]  <= 14'd8192;
        press_q[c] <= 7'd0;
        timb_q[c]  <= 7'd64;
        pnum_q[c]  <= 14'd0;
      end
    end else begin
      res_valid_q <= emit_v;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOWER_MEMBERS:   lcnt_q     <= cfg_data_i[3:0];
          CFG_UPPER_MEMBERS:   ucnt_q     <= cfg_data_i[3:0];
          CFG_LOWER_MEM_RANGE: lmem_rng_q <= cfg_data_i;
          CFG_UPPER_MEM_RANGE: umem_rng_q <= cfg_data_i;
          CFG_LOWER_MAS_RANGE: lmas_rng_q <= cfg_data_i;
          CFG_UPPER_MAS_RANGE: umas_rng_q <= cfg_data_i;
          CFG_HONOUR:          honour_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == S_DECODE && msg_ok) begin
        if (is_on && free_hit) begin
          active_q[alloc_slot] <= 1'b1;
          next_id_q <= next_id_q + 32'd1;
        end
        if (is_off) begin
          walk_mask_q <= chan_mask;
        end
        if (is_expr) begin
          walk_mask_q <= member ? chan_mask : zone_mask;
          case (typ)
            MSG_BEND:       bend_q[ch]  <= {d2_q, d1_q};
            MSG_CHAN_PRESS: press_q[ch] <= d1_q;
            default:        timb_q[ch]  <= d2_q;
          endcase
        end
        if (is_param) begin
          if (d1_q == CC_RPN_MSB) begin
            pnum_q[ch] <= pval_q[ch] ? {d2_q, pnum_q[ch][6:0]} : {d2_q, 7'd0};
            pval_q[ch] <= 1'b1;
          end else if (d1_q == CC_RPN_LSB) begin
            pnum_q[ch] <= pval_q[ch] ? {pnum_q[ch][13:7], d2_q} : {7'd0, d2_q};
            pval_q[ch] <= 1'b1;
          end else if (d1_q == CC_DATA_ENTRY && pval_q[ch]) begin
            if (pnum_q[ch] == RPN_ZONE_SIZE) begin
              if (honour_q && ch == LOWER_MASTER) lcnt_q <= size_clamp;
              else if (honour_q && ch == UPPER_MASTER) ucnt_q <= size_clamp;
            end else if (pnum_q[ch] == RPN_BEND_RANGE) begin
              if (master && lower) lmas_rng_q <= d2_q;
              else if (master) umas_rng_q <= d2_q;
              else if (lower) lmem_rng_q <= d2_q;
              else umem_rng_q <= d2_q;
            end
          end
        end
      end
      if (state_q == S_WALK) begin
        walk_mask_q <= mask_d;
        pend_q      <= pend_d;
        if (match) active_q[pend_slot_q] <= 1'b0;
      end else begin
        pend_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      st_q    <= status_byte_i;
      d1_q    <= data_first_i;
      d2_q    <= data_second_i;
      frame_q <= frame_offset_i;
    end
    if (state_q == S_DECODE) begin
      noteon_q   <= is_on;
      off_q      <= is_off;
      new_id_q   <= next_id_q + 32'd1;
      bend_op_q  <= bend_q[ch];
      rng_op_q   <= mem_rng;
      press_op_q <= press_q[ch];
      timb_op_q  <= timb_q[ch];
      walk_idx_q <= member ? {ch, 2'b00} : 6'd0;
      vsel_q     <= SEL_PITCH;
      if (is_expr) begin
        case (typ)
          MSG_BEND: begin
            vsel_q    <= SEL_PITCH;
            bend_op_q <= {d2_q, d1_q};
            rng_op_q  <= member ? mem_rng : mas_rng;
          end
          MSG_CHAN_PRESS: begin
            vsel_q     <= SEL_PRESS;
            press_op_q <= d1_q;
          end
          default: begin
            vsel_q    <= SEL_TIMBRE;
            timb_op_q <= d2_q;
          end
        endcase
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= bend_off * signed'({1'b0, rng_op_q});
    end
    if (state_q == S_LOAD) begin
      case (vsel_q)
        SEL_PITCH: begin
          val_base_q <= {1'b0, prod_q[19:0], 3'b000};
          val_tail_q <= {1'b0, prod_q[19:0], 3'b000} + PITCH_HALF;
        end
        default: begin
          val_base_q <= {8'd0, unit_prod};
          val_tail_q <= {15'd0, unit_op, 2'b00} + UNIT_HALF;
        end
      endcase
    end
    if (store_v) begin
      case (vsel_q)
        SEL_PITCH: pitch_val_q <= store_val;
        SEL_PRESS: press_val_q <= store_val;
        default:   timb_val_q  <= store_val;
      endcase
      if (noteon_q) begin
        case (vsel_q)
          SEL_PITCH: vsel_q <= SEL_PRESS;
          default:   vsel_q <= SEL_TIMBRE;
        endcase
      end
      emit_cnt_q <= 2'd0;
    end
    if (state_q == S_NOTEON) emit_cnt_q <= emit_cnt_q + 2'd1;
    if (state_q == S_WALK) begin
      walk_idx_q  <= walk_idx_q + 6'd1;
      pend_slot_q <= walk_idx_q;
      pend_last_q <= (w_rem == '0);
    end
    if (emit_v) begin
      res_frame_q <= frame_q;
      res_id_q    <= emit_id;
      res_kind_q  <= emit_kind;
      res_ch_q    <= emit_ch;
      res_key_q   <= emit_key;
      res_vel_q   <= emit_vel;
      res_val_q   <= emit_val;
      res_last_q  <= emit_last;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_valid_o  = res_valid_q;
  assign event_frame_o   = res_frame_q;
  assign note_id_o       = res_id_q;
  assign event_kind_o    = res_kind_q;
  assign event_channel_o = res_ch_q;
  assign note_key_o      = res_key_q;
  assign note_velocity_o = res_vel_q;
  assign event_value_o   = res_val_q;
  assign last_of_run_o   = res_last_q;

  `ASSERT_CHK(a_last_ends_run, res_valid_q && res_last_q |=> !res_valid_q)
  `ASSERT_CHK(a_accept_busy, start_i && !busy_o |=> busy_o)
  `ASSERT_NEVER(a_kind_range, res_valid_q && (res_kind_q > KIND_TIMBRE))
  `ASSERT_NEVER(a_idle_no_pend, state_q == S_IDLE && pend_q)

endmodule
